// ===== rtl/fbpa_pkg.sv =====
// Shared types, constants and codes of the fixed block pool allocator.
// No dependencies; all other files but fbpa_chan_if_dummy refer to this package.
`default_nettype none

package fbpa_pkg;

	// Pool geometry
	localparam int MAX_BLOCKS = 1024;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int DEPTH_W    = IDX_W + 1;

	// Field and register widths
	localparam int OFF_W      = 32;
	localparam int DIVIDEND_W = OFF_W - 1;
	localparam int SIZE_W     = 17;
	localparam int COUNT_W    = 11;
	localparam int OUT_OFF_W  = 26;
	localparam int STATUS_W   = 2;
	localparam int ACC_W      = SIZE_W + IDX_W;

	// Iterative unit step counts
	localparam int DIV_STEPS  = DIVIDEND_W;
	localparam int MUL_STEPS  = IDX_W;
	localparam int CNT_W      = $clog2(DIV_STEPS + 1);

	// Configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic REG_IDX_SIZE  = 1'b0;
	localparam logic REG_IDX_COUNT = 1'b1;

	// Register reset values and clamp limits
	localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(16);
	localparam logic [SIZE_W-1:0]  SIZE_MIN    = SIZE_W'(16);
	localparam logic [SIZE_W-1:0]  SIZE_MAX    = SIZE_W'(65536);
	localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);
	localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(MAX_BLOCKS);

	// Request and status codes
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;
	localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd2;

	typedef struct packed {
		logic [SIZE_W-1:0]  block_size;
		logic [COUNT_W-1:0] block_count;
	} cfg_t;

	typedef struct packed {
		logic                  start;
		logic                  op_div;
		logic [DIVIDEND_W-1:0] a;
		logic [SIZE_W-1:0]     b;
	} arith_req_t;

	typedef struct packed {
		logic                  busy;
		logic                  done;
		logic [DIVIDEND_W-1:0] quo;
		logic [ACC_W-1:0]      acc;
	} arith_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/fbpa_chan_if.sv =====
// Request and result channels of the allocator: valid/ready plus payload.
// Depends on fbpa_pkg for field widths.
`default_nettype none

interface fbpa_req_if;
	logic                                valid;
	logic                                ready;
	logic                                req_type;
	logic signed [fbpa_pkg::OFF_W-1:0]   free_offset;
	logic                                free_null;

	modport source (output valid, output req_type, output free_offset, output free_null,
		input ready);
	modport sink (input valid, input req_type, input free_offset, input free_null,
		output ready);
endinterface

interface fbpa_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [fbpa_pkg::STATUS_W-1:0]     status;
	logic [fbpa_pkg::OUT_OFF_W-1:0]    block_offset;
	logic [fbpa_pkg::COUNT_W-1:0]      used_count;

	modport source (output valid, output status, output block_offset, output used_count,
		input ready);
	modport sink (input valid, input status, input block_offset, input used_count,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/fixed_block_pool_allocator_core.sv =====
// Fixed block pool allocator. An allocate takes the most recently freed
// block index from a LIFO stack held in a 1024 x 10 memory, otherwise the
// next never-used index, and returns index times block size as a byte offset
// (status 1 when the pool is empty). A free checks the byte offset for null,
// sign, divisibility by the block size and range against the block count,
// then pushes the index. One shared shift/add unit does both jobs one bit per
// cycle, and it sets the time an item takes. After acceptance, an allocate of
// a never-used block goes to the multiply (10 multiply steps), an allocate off
// the freed stack first reads the stack and then multiplies, a free goes to
// the divide (31 divide steps), and an allocate that finds the pool empty or
// a free rejected as null or negative goes straight to the finish state, where
// each result waits while the output register is still held. The next item
// can be accepted in the cycle after the result is loaded. The block takes one
// item at a time; a finished result waits in an output register while the next
// item is accepted. Configure only while no item is in flight.
// Depends on fbpa_pkg, fbpa_chan_if, fbpa_cfg_regs and fbpa_arith.
`default_nettype none

module fixed_block_pool_allocator_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	fbpa_req_if.sink                             req,
	fbpa_rsp_if.source                           rsp,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [fbpa_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [fbpa_pkg::CFG_DATA_W-1:0] pwdata,
	output      logic [fbpa_pkg::CFG_DATA_W-1:0] prdata,
	output      logic                            pready
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_MUL_GO,
		ST_MUL_WAIT,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_FINISH
	} state_t;

	localparam int IW = fbpa_pkg::IDX_W;
	localparam int DPW = fbpa_pkg::DEPTH_W;

	fbpa_pkg::cfg_t       cfg;
	fbpa_pkg::arith_req_t arith_req;
	fbpa_pkg::arith_rsp_t arith_rsp;

	state_t                          state_q;
	logic [DPW-1:0]                  depth_q;
	logic [fbpa_pkg::COUNT_W-1:0]    fresh_q;
	logic [fbpa_pkg::COUNT_W-1:0]    used_q;
	logic [IW-1:0]                   idx_q;
	logic [fbpa_pkg::OFF_W-1:0]      off_q;
	logic [fbpa_pkg::STATUS_W-1:0]   res_status_q;
	logic [fbpa_pkg::OUT_OFF_W-1:0]  res_offset_q;
	logic                            rsp_valid_q;
	logic [fbpa_pkg::STATUS_W-1:0]   rsp_status_q;
	logic [fbpa_pkg::OUT_OFF_W-1:0]  rsp_offset_q;
	logic [fbpa_pkg::COUNT_W-1:0]    rsp_used_q;

	logic [IW-1:0] mem [fbpa_pkg::MAX_BLOCKS];
	logic [IW-1:0] rd_data_q;

	logic [fbpa_pkg::SIZE_W-1:0]  size_eff;
	logic [fbpa_pkg::COUNT_W-1:0] count_eff;
	logic                         accept;
	logic                         mem_rd_en;
	logic [IW-1:0]                mem_rd_addr;
	logic                         mem_we;
	logic                         free_ok;
	logic                         out_free;
	logic [DPW-1:0]               depth_dec;

	fbpa_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fbpa_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (arith_req),
		.rsp    (arith_rsp)
	);

	// Clamp the configuration to its meaningful range
	always_comb begin
		if (cfg.block_size < fbpa_pkg::SIZE_MIN) begin
			size_eff = fbpa_pkg::SIZE_MIN;
		end else if (cfg.block_size > fbpa_pkg::SIZE_MAX) begin
			size_eff = fbpa_pkg::SIZE_MAX;
		end else begin
			size_eff = cfg.block_size;
		end
		if (cfg.block_count > fbpa_pkg::COUNT_MAX) begin
			count_eff = fbpa_pkg::COUNT_MAX;
		end else begin
			count_eff = cfg.block_count;
		end
	end

	assign accept    = req.valid & req.ready;
	assign depth_dec = depth_q - 1'b1;
	assign out_free  = !rsp_valid_q || rsp.ready;

	// Stack pop read and push write
	assign mem_rd_en   = accept && (req.req_type == fbpa_pkg::REQ_ALLOC) && (depth_q != '0);
	assign mem_rd_addr = depth_dec[IW-1:0];
	assign free_ok     = (arith_rsp.acc[fbpa_pkg::SIZE_W-1:0] == '0)
		&& (arith_rsp.quo < fbpa_pkg::DIVIDEND_W'(count_eff))
		&& (depth_q < DPW'(fbpa_pkg::MAX_BLOCKS));
	assign mem_we      = (state_q == ST_DIV_WAIT) && arith_rsp.done && free_ok;

	// Drive the shared unit from the issue states
	always_comb begin
		arith_req.start  = (state_q == ST_MUL_GO) || (state_q == ST_DIV_GO);
		arith_req.op_div = (state_q == ST_DIV_GO);
		arith_req.b      = size_eff;
		if (state_q == ST_DIV_GO) begin
			arith_req.a = off_q[fbpa_pkg::DIVIDEND_W-1:0];
		end else begin
			arith_req.a = fbpa_pkg::DIVIDEND_W'(idx_q);
		end
	end

	// Freed stack memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[depth_q[IW-1:0]] <= arith_rsp.quo[IW-1:0];
		end
		if (mem_rd_en) begin
			rd_data_q <= mem[mem_rd_addr];
		end
	end

	// Sequencer, pool counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			depth_q      <= '0;
			fresh_q      <= '0;
			used_q       <= '0;
			idx_q        <= '0;
			off_q        <= '0;
			res_status_q <= fbpa_pkg::STATUS_DONE;
			res_offset_q <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= fbpa_pkg::STATUS_DONE;
			rsp_offset_q <= '0;
			rsp_used_q   <= '0;
		end else begin
			// Load a finished result, or drop the one taken
			if ((state_q == ST_FINISH) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						off_q        <= req.free_offset;
						res_offset_q <= '0;
						if (req.req_type == fbpa_pkg::REQ_ALLOC) begin
							if (depth_q != '0) begin
								depth_q <= depth_dec;
								state_q <= ST_RD;
							end else if (fresh_q < count_eff) begin
								idx_q   <= fresh_q[IW-1:0];
								fresh_q <= fresh_q + 1'b1;
								state_q <= ST_MUL_GO;
							end else begin
								res_status_q <= fbpa_pkg::STATUS_EMPTY;
								state_q      <= ST_FINISH;
							end
						end else if (req.free_null || req.free_offset[fbpa_pkg::OFF_W-1]) begin
							res_status_q <= fbpa_pkg::STATUS_REJECT;
							state_q      <= ST_FINISH;
						end else begin
							state_q <= ST_DIV_GO;
						end
					end
				end
				ST_RD: begin
					idx_q   <= rd_data_q;
					state_q <= ST_MUL_GO;
				end
				ST_MUL_GO: begin
					state_q <= ST_MUL_WAIT;
				end
				ST_MUL_WAIT: begin
					if (arith_rsp.done) begin
						res_status_q <= fbpa_pkg::STATUS_DONE;
						res_offset_q <= arith_rsp.acc[fbpa_pkg::OUT_OFF_W-1:0];
						if (used_q < fbpa_pkg::COUNT_MAX) begin
							used_q <= used_q + 1'b1;
						end
						state_q <= ST_FINISH;
					end
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (arith_rsp.done) begin
						if (free_ok) begin
							res_status_q <= fbpa_pkg::STATUS_DONE;
							depth_q      <= depth_q + 1'b1;
							if (used_q != '0) begin
								used_q <= used_q - 1'b1;
							end
						end else begin
							res_status_q <= fbpa_pkg::STATUS_REJECT;
						end
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// Hand over once the output register is free
					if (out_free) begin
						rsp_status_q <= res_status_q;
						rsp_offset_q <= res_offset_q;
						rsp_used_q   <= used_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req.ready        = (state_q == ST_IDLE);
	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.block_offset = rsp_offset_q;
	assign rsp.used_count   = rsp_used_q;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DPW'(fbpa_pkg::MAX_BLOCKS))
		else $error("freed stack depth beyond pool size");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (depth_q < DPW'(fbpa_pkg::MAX_BLOCKS)))
		else $error("push onto a full freed stack");

	a_pop_depth: assert property (@(posedge clk) disable iff (!arst_n)
		mem_rd_en |=> (depth_q == DPW'($past(depth_q) - 1'b1)))
		else $error("pop did not lower the stack depth");

	a_finish_idle_unit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> !arith_rsp.busy)
		else $error("result handed over while the shared unit still runs");

endmodule

`default_nettype wire

// ===== rtl/fbpa_cfg_regs.sv =====
// APB-style configuration registers: block size and block count.
// Depends on fbpa_pkg.
`default_nettype none

module fbpa_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [fbpa_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [fbpa_pkg::CFG_DATA_W-1:0] pwdata,
	output      logic [fbpa_pkg::CFG_DATA_W-1:0] prdata,
	output      logic                            pready,
	output      fbpa_pkg::cfg_t                  cfg
);

	logic [fbpa_pkg::SIZE_W-1:0]  size_q;
	logic [fbpa_pkg::COUNT_W-1:0] count_q;
	logic                         wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	// Write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= fbpa_pkg::SIZE_RESET;
			count_q <= fbpa_pkg::COUNT_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				fbpa_pkg::REG_IDX_SIZE:  size_q  <= pwdata[fbpa_pkg::SIZE_W-1:0];
				fbpa_pkg::REG_IDX_COUNT: count_q <= pwdata[fbpa_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		case (paddr[2])
			fbpa_pkg::REG_IDX_SIZE:  prdata = fbpa_pkg::CFG_DATA_W'(size_q);
			fbpa_pkg::REG_IDX_COUNT: prdata = fbpa_pkg::CFG_DATA_W'(count_q);
			default:                 prdata = '0;
		endcase
	end

	assign cfg.block_size  = size_q;
	assign cfg.block_count = count_q;

endmodule

`default_nettype wire

// ===== rtl/fbpa_arith.sv =====
// Shared shift/add unit: restoring divide (quotient and remainder) or
// MSB-first shift-add multiply, one bit per cycle. Depends on fbpa_pkg.
`default_nettype none

module fbpa_arith (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire fbpa_pkg::arith_req_t req,
	output      fbpa_pkg::arith_rsp_t rsp
);

	localparam int AW = fbpa_pkg::ACC_W;
	localparam int DW = fbpa_pkg::DIVIDEND_W;

	logic                          busy_q;
	logic                          done_q;
	logic                          op_div_q;
	logic [fbpa_pkg::CNT_W-1:0]    cnt_q;
	logic [DW-1:0]                 sh_q;
	logic [AW-1:0]                 acc_q;
	logic [fbpa_pkg::SIZE_W-1:0]   b_q;

	logic [AW-1:0] lhs;
	logic [AW:0]   opnd;
	logic [AW:0]   res;

	// One adder: subtract the divisor, or add it when the multiplier bit is set
	always_comb begin
		lhs = {acc_q[AW-2:0], op_div_q & sh_q[DW-1]};
		if (op_div_q) begin
			opnd = ~(AW+1)'(b_q);
		end else if (sh_q[DW-1]) begin
			opnd = (AW+1)'(b_q);
		end else begin
			opnd = '0;
		end
		res = {1'b0, lhs} + opnd + (AW+1)'(op_div_q);
	end

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			op_div_q <= 1'b0;
			cnt_q    <= '0;
			sh_q     <= '0;
			acc_q    <= '0;
			b_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q   <= 1'b1;
				op_div_q <= req.op_div;
				b_q      <= req.b;
				acc_q    <= '0;
				if (req.op_div) begin
					sh_q  <= req.a;
					cnt_q <= fbpa_pkg::CNT_W'(fbpa_pkg::DIV_STEPS - 1);
				end else begin
					sh_q  <= {req.a[fbpa_pkg::IDX_W-1:0], {(DW - fbpa_pkg::IDX_W){1'b0}}};
					cnt_q <= fbpa_pkg::CNT_W'(fbpa_pkg::MUL_STEPS - 1);
				end
			end else if (busy_q) begin
				if (op_div_q) begin
					// Keep the difference only when no borrow
					if (!res[AW]) begin
						acc_q <= res[AW-1:0];
						sh_q  <= {sh_q[DW-2:0], 1'b1};
					end else begin
						acc_q <= lhs;
						sh_q  <= {sh_q[DW-2:0], 1'b0};
					end
				end else begin
					acc_q <= res[AW-1:0];
					sh_q  <= {sh_q[DW-2:0], 1'b0};
				end
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = sh_q;
	assign rsp.acc  = acc_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q)
		else $error("arith unit not busy after start");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("arith done held for more than one cycle");

	a_mul_count: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !op_div_q) |-> (cnt_q < fbpa_pkg::CNT_W'(fbpa_pkg::MUL_STEPS)))
		else $error("multiply step count out of range");

endmodule

`default_nettype wire

// ===== rtl/fbpa_chan_if_dummy.sv =====
// Holds no logic; the request and result channels live in fbpa_chan_if.sv.
// No dependencies.
`default_nettype none

`default_nettype wire

// ===== tb/sv/fixed_block_pool_allocator_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench for fixed_block_pool_allocator_core: directed and random allocate/free items,
// predicted on the fly and checked field by field against each reply.
// Depends on fbpa_pkg, fbpa_chan_if and the allocator RTL.

module fixed_block_pool_allocator_core_tb;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int TAIL_CYCLES = 64;
	localparam int MAX_GAP     = 24;

	typedef struct packed {
		logic [fbpa_pkg::STATUS_W-1:0]  status;
		logic [fbpa_pkg::OUT_OFF_W-1:0] block_offset;
		logic [fbpa_pkg::COUNT_W-1:0]   used_count;
	} reply_t;

	logic                            clk;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [fbpa_pkg::CFG_ADDR_W-1:0] paddr;
	logic [fbpa_pkg::CFG_DATA_W-1:0] pwdata;
	logic [fbpa_pkg::CFG_DATA_W-1:0] prdata;
	logic                            pready;

	fbpa_req_if req_ch ();
	fbpa_rsp_if rsp_ch ();

	fixed_block_pool_allocator_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Pool shadow: freed-index stack, fresh index, blocks in use, registers
	logic [fbpa_pkg::IDX_W-1:0]   stack_slots [0:fbpa_pkg::MAX_BLOCKS-1];
	logic [fbpa_pkg::DEPTH_W-1:0] stack_fill;
	logic [fbpa_pkg::COUNT_W-1:0] next_fresh;
	logic [fbpa_pkg::COUNT_W-1:0] blocks_in_use;
	logic [fbpa_pkg::SIZE_W-1:0]  held_size;
	logic [fbpa_pkg::COUNT_W-1:0] held_count;

	reply_t expected_replies [$];
	int     reply_errors;
	int     allocs_sent;
	int     frees_sent;
	int     settings_used;
	int     cycle_count;
	int     send_idle_pct;
	int     recv_stall_pct;

	always #1 clk = ~clk;

	initial begin
		clk              = 1'b0;
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		req_ch.valid     = 1'b0;
		req_ch.req_type  = fbpa_pkg::REQ_ALLOC;
		req_ch.free_offset = '0;
		req_ch.free_null = 1'b0;
		rsp_ch.ready     = 1'b0;
		send_idle_pct    = 0;
		recv_stall_pct   = 0;
	end

	// Block size and count as the pool applies them
	function automatic logic [fbpa_pkg::SIZE_W-1:0] size_in_force();
		if (held_size < fbpa_pkg::SIZE_MIN)
			return fbpa_pkg::SIZE_MIN;
		if (held_size > fbpa_pkg::SIZE_MAX)
			return fbpa_pkg::SIZE_MAX;
		return held_size;
	endfunction

	function automatic logic [fbpa_pkg::COUNT_W-1:0] count_in_force();
		return (held_count > fbpa_pkg::COUNT_MAX) ? fbpa_pkg::COUNT_MAX : held_count;
	endfunction

	// Work out the reply to one request and advance the shadow pool
	function automatic reply_t pool_reply(input logic kind,
		input logic [fbpa_pkg::OFF_W-1:0] offset, input logic is_null);
		reply_t      r;
		logic [31:0] sz;
		logic [31:0] cnt;
		logic [31:0] idx;
		logic [31:0] prod;
		logic        found;
		r.status       = fbpa_pkg::STATUS_DONE;
		r.block_offset = '0;
		sz    = 32'(size_in_force());
		cnt   = 32'(count_in_force());
		idx   = '0;
		found = 1'b0;
		if (kind == fbpa_pkg::REQ_ALLOC) begin
			if (stack_fill != 0) begin
				stack_fill = stack_fill - 1'b1;
				idx        = 32'(stack_slots[stack_fill[fbpa_pkg::IDX_W-1:0]]);
				found      = 1'b1;
			end else if (32'(next_fresh) < cnt) begin
				idx        = 32'(next_fresh);
				next_fresh = next_fresh + 1'b1;
				found      = 1'b1;
			end
			if (found) begin
				prod           = idx * sz;
				r.block_offset = prod[fbpa_pkg::OUT_OFF_W-1:0];
				if (blocks_in_use < fbpa_pkg::COUNT_W'(fbpa_pkg::MAX_BLOCKS))
					blocks_in_use = blocks_in_use + 1'b1;
			end else begin
				r.status = fbpa_pkg::STATUS_EMPTY;
			end
		end else begin
			if (is_null || offset[fbpa_pkg::OFF_W-1]) begin
				r.status = fbpa_pkg::STATUS_REJECT;
			end else if (offset % sz != 0) begin
				r.status = fbpa_pkg::STATUS_REJECT;
			end else begin
				idx = offset / sz;
				if (idx >= cnt || 32'(stack_fill) >= fbpa_pkg::MAX_BLOCKS) begin
					r.status = fbpa_pkg::STATUS_REJECT;
				end else begin
					stack_slots[stack_fill[fbpa_pkg::IDX_W-1:0]] = idx[fbpa_pkg::IDX_W-1:0];
					stack_fill = stack_fill + 1'b1;
					if (blocks_in_use != 0)
						blocks_in_use = blocks_in_use - 1'b1;
				end
			end
		end
		r.used_count = blocks_in_use;
		return r;
	endfunction

	// Hold one item on the request channel until it is taken, after a random gap
	task automatic send_item(input logic kind, input logic [fbpa_pkg::OFF_W-1:0] offset,
		input logic is_null);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.req_type    <= kind;
		req_ch.free_offset <= offset;
		req_ch.free_null   <= is_null;
		do @(posedge clk); while (!req_ch.ready);
		expected_replies.push_back(pool_reply(kind, offset, is_null));
		if (kind == fbpa_pkg::REQ_ALLOC)
			allocs_sent++;
		else
			frees_sent++;
	endtask

	// Drop valid and wait until every predicted reply has arrived
	task automatic drain_replies();
		req_ch.valid <= 1'b0;
		while (expected_replies.size() != 0)
			@(posedge clk);
	endtask

	// Register write: setup cycle, access cycle until pready, then back to idle
	task automatic cfg_write(input logic reg_idx,
		input logic [fbpa_pkg::CFG_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		if (reg_idx == fbpa_pkg::REG_IDX_SIZE)
			held_size = value[fbpa_pkg::SIZE_W-1:0];
		else
			held_count = value[fbpa_pkg::COUNT_W-1:0];
	endtask

	task automatic set_pool(input logic [fbpa_pkg::CFG_DATA_W-1:0] size,
		input logic [fbpa_pkg::CFG_DATA_W-1:0] count);
		drain_replies();
		cfg_write(fbpa_pkg::REG_IDX_SIZE, size);
		cfg_write(fbpa_pkg::REG_IDX_COUNT, count);
		settings_used++;
	endtask

	// Reset settings: fresh blocks, rejections of each kind, LIFO reuse, repeated free
	task automatic test_reset_settings();
		send_item(fbpa_pkg::REQ_FREE, 32'd0, 1'b0);
		send_item(fbpa_pkg::REQ_ALLOC, 32'hFFFF_FFFF, 1'b1);
		send_item(fbpa_pkg::REQ_ALLOC, 32'd0, 1'b0);
		send_item(fbpa_pkg::REQ_ALLOC, 32'd0, 1'b0);
		send_item(fbpa_pkg::REQ_FREE, 32'd16, 1'b1);
		send_item(fbpa_pkg::REQ_FREE, 32'h8000_0000, 1'b0);
		send_item(fbpa_pkg::REQ_FREE, 32'hFFFF_FFFF, 1'b0);
		send_item(fbpa_pkg::REQ_FREE, 32'd17, 1'b0);
		send_item(fbpa_pkg::REQ_FREE, 32'd16384, 1'b0);
		send_item(fbpa_pkg::REQ_FREE, 32'h7FFF_FFFF, 1'b0);
		send_item(fbpa_pkg::REQ_FREE, 32'h7FFF_FFF0, 1'b0);
		send_item(fbpa_pkg::REQ_FREE, 32'd16368, 1'b0);
		send_item(fbpa_pkg::REQ_FREE, 32'd0, 1'b0);
		send_item(fbpa_pkg::REQ_FREE, 32'd0, 1'b0);
		send_item(fbpa_pkg::REQ_ALLOC, 32'd0, 1'b0);
		send_item(fbpa_pkg::REQ_ALLOC, 32'd0, 1'b0);
		send_item(fbpa_pkg::REQ_ALLOC, 32'd0, 1'b0);
		send_item(fbpa_pkg::REQ_ALLOC, 32'd0, 1'b0);
	endtask

	// Register extremes: empty pool, one block, clamped size and count
	task automatic test_register_extremes();
		set_pool(32'd15, 32'd0);
		send_item(fbpa_pkg::REQ_ALLOC, 32'd0, 1'b0);
		send_item(fbpa_pkg::REQ_FREE, 32'd0, 1'b0);
		set_pool(32'd0, 32'd1);
		send_item(fbpa_pkg::REQ_FREE, 32'd0, 1'b0);
		send_item(fbpa_pkg::REQ_ALLOC, 32'd0, 1'b0);
		send_item(fbpa_pkg::REQ_ALLOC, 32'd0, 1'b0);
		set_pool(32'h1_FFFF, 32'h7FF);
		send_item(fbpa_pkg::REQ_ALLOC, 32'd0, 1'b0);
		send_item(fbpa_pkg::REQ_FREE, 32'd1023 * 32'd65536, 1'b0);
		send_item(fbpa_pkg::REQ_FREE, 32'd1024 * 32'd65536, 1'b0);
		send_item(fbpa_pkg::REQ_FREE, 32'd65537, 1'b0);
		send_item(fbpa_pkg::REQ_ALLOC, 32'd0, 1'b0);
	endtask

	// Fill the freed stack to the brim, then push past it
	task automatic test_full_freed_stack();
		set_pool(32'd16, 32'd1024);
		while (32'(stack_fill) < fbpa_pkg::MAX_BLOCKS)
			send_item(fbpa_pkg::REQ_FREE,
				32'($urandom_range(fbpa_pkg::MAX_BLOCKS - 1)) * 32'd16, 1'b0);
		send_item(fbpa_pkg::REQ_FREE, 32'd0, 1'b0);
		send_item(fbpa_pkg::REQ_FREE, 32'd16368, 1'b0);
		send_item(fbpa_pkg::REQ_ALLOC, 32'd0, 1'b0);
	endtask

	// Random traffic under one pool setting and one pacing
	task automatic test_random_traffic(input int send_pct, input int recv_pct,
		input logic [fbpa_pkg::CFG_DATA_W-1:0] size,
		input logic [fbpa_pkg::CFG_DATA_W-1:0] count, input int items);
		int          pick;
		logic [31:0] sz;
		logic [31:0] cnt;
		logic [31:0] idx;
		set_pool(size, count);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		for (int n = 0; n < items; n++) begin
			pick = $urandom_range(99);
			sz   = 32'(size_in_force());
			cnt  = 32'(count_in_force());
			idx  = (cnt == 0) ? 32'd0 : 32'($urandom_range(cnt - 1));
			if (pick < 45)
				send_item(fbpa_pkg::REQ_ALLOC, $urandom, 1'($urandom));
			else if (pick < 83)
				send_item(fbpa_pkg::REQ_FREE, idx * sz, 1'b0);
			else if (pick < 87)
				send_item(fbpa_pkg::REQ_FREE, idx * sz + 32'($urandom_range(sz - 1, 1)), 1'b0);
			else if (pick < 91)
				send_item(fbpa_pkg::REQ_FREE, (cnt + 32'($urandom_range(64))) * sz, 1'b0);
			else if (pick < 95)
				send_item(fbpa_pkg::REQ_FREE, $urandom | 32'h8000_0000, 1'b0);
			else if (pick < 98)
				send_item(fbpa_pkg::REQ_FREE, $urandom, 1'b1);
			else
				send_item(fbpa_pkg::REQ_FREE, $urandom, 1'($urandom));
		end
	endtask

	// Receiver: stall at random according to the phase
	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Compare each reply with the oldest prediction
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_replies.size() == 0) begin
				$error("reply with no request pending: status %0d", rsp_ch.status);
				reply_errors++;
			end else begin
				want = expected_replies.pop_front();
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
					reply_errors++;
				end
				if (rsp_ch.block_offset !== want.block_offset) begin
					$error("block_offset: expected %0d, actual %0d",
						want.block_offset, rsp_ch.block_offset);
					reply_errors++;
				end
				if (rsp_ch.used_count !== want.used_count) begin
					$error("used_count: expected %0d, actual %0d",
						want.used_count, rsp_ch.used_count);
					reply_errors++;
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies outstanding",
				cycle_count, expected_replies.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		stack_fill    = '0;
		next_fresh    = '0;
		blocks_in_use = '0;
		held_size     = fbpa_pkg::SIZE_RESET;
		held_count    = fbpa_pkg::COUNT_RESET;
		reply_errors  = 0;
		allocs_sent   = 0;
		frees_sent    = 0;
		settings_used = 1;
		cycle_count   = 0;

		// Hold reset, then release it
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_settings();
		test_register_extremes();
		test_full_freed_stack();
		test_random_traffic(0, 0, 32'd16, 32'($urandom_range(32, 2)), 240);
		test_random_traffic(69, 0, 32'h1_FFFF, 32'h7FF, 240);
		test_random_traffic(0, 69, 32'($urandom_range(65536, 16)),
			32'($urandom_range(1024, 1)), 240);
		test_random_traffic(30, 30, 32'($urandom_range(15)), 32'($urandom_range(16, 1)), 240);

		drain_replies();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d allocations and %0d frees over %0d pool settings,",
			allocs_sent, frees_sent, settings_used);
		$display("with a full freed stack and four pacing phases; %0d mismatches",
			reply_errors);
		if (reply_errors == 0 && expected_replies.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/fbpa_pkg.sv
rtl/fbpa_chan_if.sv
rtl/fbpa_cfg_regs.sv
rtl/fbpa_arith.sv
rtl/fbpa_chan_if_dummy.sv
rtl/fixed_block_pool_allocator_core.sv
tb/sv/fixed_block_pool_allocator_core_tb.sv
